@@ rtl/rgb_led_strip_frame_serializer_core_assert.svh @@
// Assertion macros for the serializer RTL.
`ifndef RGB_LED_STRIP_FRAME_SERIALIZER_CORE_ASSERT_SVH
`define RGB_LED_STRIP_FRAME_SERIALIZER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RLFS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RLFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rlfs_pkg.sv @@
// Types and constants shared by the LED frame serializer.
package rlfs_pkg;

  localparam int COUNT_W = 10;   // led_count register width
  localparam int POS_W   = 13;   // frame position, active LED count
  localparam int QDEPTH  = 2;    // front-to-back queue depth
  localparam int COLOR_W = 24;

  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_PULL  = 2'd2;

  localparam logic [7:0]       BYTE_ZEROS  = 8'h00;
  localparam logic [7:0]       BYTE_ONES   = 8'hFF;
  localparam logic [POS_W-1:0] START_BYTES = 13'd4;
  localparam logic [POS_W-1:0] END_ROUND   = 13'd15;  // LEDs per end byte, less one
  localparam int               END_SHIFT   = 4;

  typedef enum logic [1:0] {
    OP_SET,
    OP_CLEAR,
    OP_PULL
  } op_t;

  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_ONES,
    KIND_BLUE,
    KIND_GREEN,
    KIND_RED
  } byte_kind_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } back_state_t;

  typedef struct packed {
    op_t              op;
    logic [8:0]       led_index;
    logic [COLOR_W-1:0] color;   // {red, green, blue}
  } cmd_word_t;

endpackage

@@ rtl/rlfs_cmd_if.sv @@
// Command channel: valid/ready plus command payload.
interface rlfs_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [8:0] led_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, cmd, led_index, red, green, blue, input ready);
  modport sink   (input valid, cmd, led_index, red, green, blue, output ready);
endinterface

@@ rtl/rlfs_byte_if.sv @@
// Frame byte channel: valid/ready plus byte and last flag.
interface rlfs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       frame_last;

  modport source (output valid, spi_byte, frame_last, input ready);
  modport sink   (input valid, spi_byte, frame_last, output ready);
endinterface

@@ rtl/rlfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rlfs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/rlfs_front.sv @@
// Front end: takes command words, drops the unused code, queues the rest.
module rlfs_front (
  input  logic               clk,
  input  logic               rst,
  rlfs_cmd_if.sink           cmd_link,
  output logic               word_valid,
  input  logic               word_ready,
  output rlfs_pkg::cmd_word_t word
);
  import rlfs_pkg::*;

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_word_t        q_mem [QDEPTH];
  logic [QAW-1:0]   wptr;
  logic [QAW-1:0]   rptr;
  logic [QAW:0]     count;
  logic [QAW:0]     count_next;
  logic             take;
  logic             push;
  logic             pop;
  logic             keep;
  cmd_word_t        in_word;

  // Classify the incoming command.
  always_comb begin
    keep       = 1'b1;
    in_word.op = OP_SET;
    case (cmd_link.cmd)
      CMD_SET:   in_word.op = OP_SET;
      CMD_CLEAR: in_word.op = OP_CLEAR;
      CMD_PULL:  in_word.op = OP_PULL;
      default:   keep = 1'b0;   // reserved code: no effect
    endcase
    in_word.led_index = cmd_link.led_index;
    in_word.color     = {cmd_link.red, cmd_link.green, cmd_link.blue};
  end

  assign cmd_link.ready = (count != (QAW+1)'(QDEPTH));
  assign take           = cmd_link.valid && cmd_link.ready;
  assign push           = take && keep;
  assign word_valid     = (count != '0);
  assign pop            = word_valid && word_ready;
  assign word           = q_mem[rptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wptr <= (wptr == QAW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QAW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wptr] <= in_word;
    end
  end

endmodule

@@ rtl/rlfs_back.sv @@
// Back end: pixel store, clear sweep, frame position and byte output.
`include "rgb_led_strip_frame_serializer_core_assert.svh"

module rlfs_back #(
  parameter int MAX_LEDS = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rlfs_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                          word_valid,
  output logic                          word_ready,
  input  rlfs_pkg::cmd_word_t           word,
  rlfs_byte_if.source                   byte_link
);
  import rlfs_pkg::*;

  localparam int               AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam logic [POS_W-1:0] MAX_N = POS_W'(MAX_LEDS);

  back_state_t        state;
  back_state_t        state_next;
  logic [AW-1:0]      sweep_cnt;
  logic               sweep_done;
  logic               sweeping;

  logic [COUNT_W-1:0] led_count;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   n_act;
  logic [POS_W-1:0]   data_end;
  logic [POS_W-1:0]   last_pos;
  logic [POS_W-1:0]   pos_cur;
  logic               pos_last;
  logic [POS_W-1:0]   q;
  logic [POS_W-1:0]   led_sel;
  logic [POS_W-1:0]   idx_ext;
  byte_kind_t         kind;

  logic               issue;
  logic               s1_valid;
  logic               s1_move;
  byte_kind_t         s1_kind;
  logic               s1_last;

  logic               out_valid;
  logic [7:0]         out_byte;
  logic               out_last;
  logic [7:0]         byte_next;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [COLOR_W-1:0] ram_wdata;
  logic               ram_re;
  logic [COLOR_W-1:0] ram_rdata;

  // Frame geometry from the count register.
  always_comb begin
    n_act    = (POS_W'(led_count) > MAX_N) ? MAX_N : POS_W'(led_count);
    data_end = START_BYTES + (n_act << 2);
    last_pos = data_end + ((n_act + END_ROUND) >> END_SHIFT) - 1'b1;
  end

  // Byte at the current frame position.
  always_comb begin
    pos_cur  = (pos <= last_pos) ? pos : '0;
    pos_last = (pos_cur == last_pos);
    q        = pos_cur - START_BYTES;
    led_sel  = q >> 2;
    if (pos_cur < START_BYTES) begin
      kind = KIND_ZERO;
    end else if (pos_cur < data_end) begin
      case (q[1:0])
        2'd0:    kind = KIND_ONES;
        2'd1:    kind = KIND_BLUE;
        2'd2:    kind = KIND_GREEN;
        default: kind = KIND_RED;
      endcase
    end else begin
      kind = KIND_ONES;
    end
  end

  // Sequencer: store sweep after reset and clear, else run commands.
  assign sweep_done = (sweep_cnt == AW'(MAX_LEDS - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (sweep_done) state_next = ST_RUN;
      ST_RUN:   if (issue && word.op == OP_CLEAR) state_next = ST_CLEAR;
      default:  state_next = ST_CLEAR;
    endcase
  end

  assign s1_move = s1_valid && (!out_valid || byte_link.ready);

  always_comb begin
    sweeping   = 1'b0;
    word_ready = 1'b0;
    case (state)
      ST_CLEAR: sweeping   = 1'b1;
      ST_RUN:   word_ready = !s1_valid || s1_move;
      default:  sweeping   = 1'b1;
    endcase
  end

  assign issue   = word_valid && word_ready;
  assign idx_ext = POS_W'(word.led_index);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_ext[AW-1:0];
    ram_wdata = word.color;
    if (sweeping) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_cnt;
      ram_wdata = '0;
    end else if (issue && word.op == OP_SET && idx_ext < n_act) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = issue && word.op == OP_PULL;

  rlfs_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MAX_LEDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (led_sel[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep_cnt <= '0;
      led_count <= '0;
      pos       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sweep_cnt <= sweeping ? sweep_cnt + 1'b1 : '0;
      if (cfg_we) begin
        led_count <= cfg_data;
        pos       <= '0;
      end else if (issue) begin
        pos <= (word.op == OP_PULL && !pos_last) ? pos_cur + 1'b1 : '0;
      end
      if (ram_re) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (byte_link.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    case (s1_kind)
      KIND_ZERO:  byte_next = BYTE_ZEROS;
      KIND_ONES:  byte_next = BYTE_ONES;
      KIND_BLUE:  byte_next = ram_rdata[7:0];
      KIND_GREEN: byte_next = ram_rdata[15:8];
      KIND_RED:   byte_next = ram_rdata[23:16];
      default:    byte_next = BYTE_ONES;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_kind <= kind;
      s1_last <= pos_last;
    end
    if (s1_move) begin
      out_byte <= byte_next;
      out_last <= s1_last;
    end
  end

  assign byte_link.valid      = out_valid;
  assign byte_link.spi_byte   = out_byte;
  assign byte_link.frame_last = out_last;

  `RLFS_ASSERT_IMPL(a_no_issue_in_sweep, state == ST_CLEAR, !word_ready, "command taken during sweep")
  `RLFS_ASSERT_IMPL(a_pos_in_frame, 1'b1, pos <= last_pos, "frame position beyond frame")
  `RLFS_ASSERT_IMPL(a_last_is_delim, out_valid && out_last, out_byte == BYTE_ONES || out_byte == BYTE_ZEROS, "last byte not a delimiter")
  `RLFS_ASSERT_NEXT(a_s1_holds, s1_valid && !s1_move, s1_valid, "stalled read stage lost")

endmodule

@@ rtl/rgb_led_strip_frame_serializer_core.sv @@
// LED chain frame serializer. Commands arrive on cmd_link as words (set pixel,
// clear all, pull byte); each pull returns one frame byte on byte_link. The
// front end queues up to two command words, so a stalled byte output does not
// block input until the queue fills. The back end takes one command word per cycle
// unless the byte output stalls; a pull reads the store at the queue head into the
// read register, then moves to the output register, and back-to-back pulls stream
// one byte per cycle while byte_link is ready. After reset and after each clear
// command the back end sweeps the pixel store through its single write port, one
// entry per cycle, until all MAX_LEDS entries are clear, and takes no command word
// meanwhile; cfg_we writes are taken at any time. The frame is four 0x00 bytes,
// then 0xFF, blue, green, red per LED, then one 0xFF per started group of sixteen
// LEDs; the final byte carries frame_last and the position wraps. A set, a clear
// and a led_count write restart the frame. Out-of-range sets are dropped, counts
// above MAX_LEDS act as MAX_LEDS, and command code 3 is ignored.
module rgb_led_strip_frame_serializer_core #(
  parameter int MAX_LEDS = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rlfs_pkg::COUNT_W-1:0] cfg_data,
  rlfs_cmd_if.sink                     cmd_link,
  rlfs_byte_if.source                  byte_link
);
  import rlfs_pkg::*;

  // Classified command words between the two halves.
  logic      word_valid;
  logic      word_ready;
  cmd_word_t word;

  rlfs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_link   (cmd_link),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word)
  );

  // Store, sweep, frame position and output register.
  rlfs_back #(
    .MAX_LEDS (MAX_LEDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word),
    .byte_link  (byte_link)
  );

endmodule
